>>> hdl/table_linear_interpolator_assert.svh
// Assertion macros used by the interpolator RTL.
`ifndef TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH
`define TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH

// Check a consequence in the same cycle as its trigger.
`define TLI_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("table_linear_interpolator: same-cycle check failed");

// Check a consequence in the cycle after its trigger.
`define TLI_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("table_linear_interpolator: next-cycle check failed");

`endif

>>> hdl/tli_pkg.sv
// Shared constants, types and codes of the table linear interpolator.
package tli_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // Field widths
   localparam int KEY_W       = 16;
   localparam int VAL_W       = 16;
   localparam int INDEX_W     = 6;
   localparam int COUNT_CFG_W = 7;
   localparam int STATUS_W    = 3;
   localparam int ENTRY_W     = KEY_W + VAL_W;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 16;

   // Serial divider sizing: quotient is known to stay below 2^17
   localparam int DIV_N_W   = 34;
   localparam int DIV_D_W   = 17;
   localparam int DIV_Q_W   = 17;
   localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

   typedef logic [ADDR_W-1:0]    addr_type;
   typedef logic [CNT_W-1:0]     count_type;
   typedef logic [DIV_CNT_W-1:0] div_count_type;
   typedef logic [STATUS_W-1:0]  status_type;

   // Result status codes
   localparam status_type ST_LOADED        = 3'd0;
   localparam status_type ST_EXACT         = 3'd1;
   localparam status_type ST_INTERP        = 3'd2;
   localparam status_type ST_OUT_OF_BOUNDS = 3'd3;
   localparam status_type ST_EMPTY         = 3'd4;

   // Operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Divider status toward the sequencer
   typedef struct packed {
      logic               busy;
      logic               done;
      logic [DIV_Q_W-1:0] quotient;
   } div_result_type;

endpackage

>>> hdl/tli_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module tli_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/tli_divider.sv
// Restoring serial divider, one quotient bit per cycle.
module tli_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tli_pkg::DIV_N_W-1:0]   dividend,
   input  logic [tli_pkg::DIV_D_W-1:0]   divisor,
   output tli_pkg::div_result_type       result
);

   logic [tli_pkg::DIV_D_W-1:0] rem_ff, rem_in;
   logic [tli_pkg::DIV_Q_W-1:0] low_ff, low_in;
   logic [tli_pkg::DIV_D_W-1:0] den_ff, den_in;
   tli_pkg::div_count_type      cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;

   logic [tli_pkg::DIV_D_W:0]   trial;
   logic [tli_pkg::DIV_D_W:0]   diff;
   logic                        fits;

   // Shift in the next dividend bit and trial-subtract the divisor
   assign trial = {rem_ff, low_ff[tli_pkg::DIV_Q_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = !diff[tli_pkg::DIV_D_W];

   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // High part is already below the divisor, so only the low bits iterate
         rem_in  = dividend[tli_pkg::DIV_N_W-1 -: tli_pkg::DIV_D_W];
         low_in  = dividend[tli_pkg::DIV_Q_W-1:0];
         den_in  = divisor;
         cnt_in  = tli_pkg::div_count_type'(tli_pkg::DIV_Q_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[tli_pkg::DIV_D_W-1:0] : trial[tli_pkg::DIV_D_W-1:0];
         low_in = {low_ff[tli_pkg::DIV_Q_W-2:0], fits};
         cnt_in = cnt_ff - tli_pkg::div_count_type'(1);
         if (cnt_ff == tli_pkg::div_count_type'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      den_ff <= den_in;
   end

   assign result.busy     = busy_ff;
   assign result.done     = done_ff;
   assign result.quotient = low_ff;

endmodule

>>> hdl/table_linear_interpolator.sv
// Piecewise linear interpolation table: sequencer, table RAM and divider.
//
// Channels: req_* carries load and query words, rsp_* returns one result word
// for each request, csr_* writes entries_in_use (always ready).
// A load (req_tuser = 0) writes one (key, value) pair into the table RAM and
// answers status 0 through the emit step.
// A query (req_tuser = 1) reads the first n = min(entries_in_use, depth) slots
// from the table RAM, one per cycle, tracking least and greatest key, first
// exact match and the bracketing keys in the same pass. A miss inside the
// bounds then runs one 17x17 multiply and a 17-step serial divider.
// A query goes from the scan to the evaluate and emit steps on reject or exact
// match, and through the multiply, start and divide steps when it interpolates;
// an empty table goes to emit at once. One request is in work at a time.
// The result register frees the sequencer: a new request is accepted while
// the previous result still waits for rsp_tready. A stalled receiver holds
// the finished result in the emit step until the result register drains.
// Reset clears the sequencer, the result valid and entries_in_use; table
// contents are undefined until loaded.
module table_linear_interpolator (
   input  logic                              clock,
   input  logic                              reset,
   // Request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [5:0] entry_index, [21:6] key_in, [37:22] value_in, [39:38] zero
   input  logic [tli_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] operation
   input  logic [0:0]                        req_tuser,
   // Result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [15:0] value_out
   output logic [tli_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [2:0] status
   output logic [tli_pkg::STATUS_W-1:0]      rsp_tuser,
   // Configuration write
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tli_pkg::COUNT_CFG_W-1:0]   csr_data
);

   // Sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_EVAL  = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_START = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_EMIT  = 3'd6;

   // Request fields
   logic                                req_op;
   logic [tli_pkg::INDEX_W-1:0]         req_index;
   logic signed [tli_pkg::KEY_W-1:0]    req_key;
   logic signed [tli_pkg::VAL_W-1:0]    req_val;

   assign req_op    = req_tuser[0];
   assign req_index = req_tdata[tli_pkg::INDEX_W-1:0];
   assign req_key   = req_tdata[tli_pkg::INDEX_W +: tli_pkg::KEY_W];
   assign req_val   = req_tdata[tli_pkg::INDEX_W+tli_pkg::KEY_W +: tli_pkg::VAL_W];

   // Registers
   logic [2:0]                          state_ff, state_in;
   logic [tli_pkg::COUNT_CFG_W-1:0]     entries_ff, entries_in;
   tli_pkg::count_type                  n_ff, n_in;
   tli_pkg::count_type                  rd_addr_ff, rd_addr_in;
   logic                                rdv_ff, rdv_in;
   logic                                first_ff, first_in;
   logic signed [tli_pkg::KEY_W-1:0]    q_ff, q_in;
   logic signed [tli_pkg::KEY_W-1:0]    kmin_ff, kmin_in;
   logic signed [tli_pkg::KEY_W-1:0]    kmax_ff, kmax_in;
   logic                                have_x_ff, have_x_in;
   logic signed [tli_pkg::VAL_W-1:0]    xv_ff, xv_in;
   logic                                have_a_ff, have_a_in;
   logic signed [tli_pkg::KEY_W-1:0]    a_ff, a_in;
   logic signed [tli_pkg::VAL_W-1:0]    va_ff, va_in;
   logic                                have_c_ff, have_c_in;
   logic signed [tli_pkg::KEY_W-1:0]    c_ff, c_in;
   logic signed [tli_pkg::VAL_W-1:0]    vc_ff, vc_in;
   logic signed [16:0]                  dq_ff, dq_in;
   logic signed [16:0]                  dv_ff, dv_in;
   logic [15:0]                         den_ff, den_in;
   logic signed [33:0]                  prod_ff, prod_in;
   logic                                neg_ff, neg_in;
   logic [tli_pkg::RSP_DATA_W-1:0]      pend_value_ff, pend_value_in;
   tli_pkg::status_type                 pend_status_ff, pend_status_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [tli_pkg::RSP_DATA_W-1:0]      rsp_value_ff, rsp_value_in;
   tli_pkg::status_type                 rsp_status_ff, rsp_status_in;

   // Table RAM and divider hookup
   logic                                ram_wr_en;
   logic                                ram_rd_en;
   logic [tli_pkg::ENTRY_W-1:0]         ram_rd_data;
   logic signed [tli_pkg::KEY_W-1:0]    rd_key;
   logic signed [tli_pkg::VAL_W-1:0]    rd_val;
   logic                                div_start;
   logic [tli_pkg::DIV_N_W-1:0]         div_dividend;
   logic [tli_pkg::DIV_D_W-1:0]         div_divisor;
   tli_pkg::div_result_type             div_res;

   // Combinational helpers
   tli_pkg::count_type                  n_sel;
   logic                                more_reads;
   logic [33:0]                         prod_mag;
   logic signed [18:0]                  quo_signed;
   logic signed [18:0]                  res_sum;
   logic [tli_pkg::RSP_DATA_W-1:0]      res_sat;
   logic signed [16:0]                  dq_w;
   logic signed [16:0]                  dv_w;
   logic signed [16:0]                  den_w;

   assign rd_key = ram_rd_data[tli_pkg::KEY_W-1:0];
   assign rd_val = ram_rd_data[tli_pkg::ENTRY_W-1:tli_pkg::KEY_W];

   tli_ram #(
      .WIDTH (tli_pkg::ENTRY_W),
      .DEPTH (tli_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tli_pkg::addr_type'(req_index)),
      .wr_data ({req_val, req_key}),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_addr_ff[tli_pkg::ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   tli_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .result   (div_res)
   );

   // Clamp the scan count to the table depth
   assign n_sel = (int'(entries_ff) > tli_pkg::TABLE_DEPTH) ?
                  tli_pkg::count_type'(tli_pkg::TABLE_DEPTH) :
                  tli_pkg::count_type'(entries_ff);
   assign more_reads = (rd_addr_ff < n_ff);

   // Bracket differences
   assign dq_w  = {q_ff[15], q_ff} - {a_ff[15], a_ff};
   assign dv_w  = {vc_ff[15], vc_ff} - {va_ff[15], va_ff};
   assign den_w = {c_ff[15], c_ff} - {a_ff[15], a_ff};

   // Round half away from zero: (2|num| + den) / (2 den)
   assign prod_mag     = neg_ff ? (34'd0 - prod_ff) : prod_ff;
   assign div_dividend = {1'b0, prod_mag[31:0], 1'b0} + {18'd0, den_ff};
   assign div_divisor  = {den_ff, 1'b0};

   // Apply sign, add the lower value and saturate
   assign quo_signed = neg_ff ? (19'sd0 - $signed({2'b00, div_res.quotient}))
                              : $signed({2'b00, div_res.quotient});
   assign res_sum    = {{3{va_ff[15]}}, va_ff} + quo_signed;
   always_comb begin
      if (res_sum > 19'sd32767) begin
         res_sat = 16'h7FFF;
      end else if (res_sum < -19'sd32768) begin
         res_sat = 16'h8000;
      end else begin
         res_sat = res_sum[15:0];
      end
   end

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      n_in           = n_ff;
      rd_addr_in     = rd_addr_ff;
      rdv_in         = rdv_ff;
      first_in       = first_ff;
      q_in           = q_ff;
      kmin_in        = kmin_ff;
      kmax_in        = kmax_ff;
      have_x_in      = have_x_ff;
      xv_in          = xv_ff;
      have_a_in      = have_a_ff;
      a_in           = a_ff;
      va_in          = va_ff;
      have_c_in      = have_c_ff;
      c_in           = c_ff;
      vc_in          = vc_ff;
      dq_in          = dq_ff;
      dv_in          = dv_ff;
      den_in         = den_ff;
      prod_in        = prod_ff;
      neg_in         = neg_ff;
      pend_value_in  = pend_value_ff;
      pend_status_in = pend_status_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_status_in  = rsp_status_ff;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;
      div_start      = 1'b0;

      // Drop the result word once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_op == tli_pkg::OP_LOAD) begin
                  ram_wr_en      = (int'(req_index) < tli_pkg::TABLE_DEPTH);
                  pend_value_in  = '0;
                  pend_status_in = tli_pkg::ST_LOADED;
                  state_in       = S_EMIT;
               end else if (n_sel == '0) begin
                  pend_value_in  = '0;
                  pend_status_in = tli_pkg::ST_EMPTY;
                  state_in       = S_EMIT;
               end else begin
                  q_in       = req_key;
                  n_in       = n_sel;
                  rd_addr_in = '0;
                  rdv_in     = 1'b0;
                  first_in   = 1'b1;
                  have_x_in  = 1'b0;
                  have_a_in  = 1'b0;
                  have_c_in  = 1'b0;
                  state_in   = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // Issue the next read
            if (more_reads) begin
               ram_rd_en  = 1'b1;
               rd_addr_in = rd_addr_ff + tli_pkg::count_type'(1);
            end
            rdv_in = more_reads;
            // Fold the entry read last cycle into the trackers
            if (rdv_ff) begin
               first_in = 1'b0;
               if (first_ff) begin
                  kmin_in = rd_key;
                  kmax_in = rd_key;
               end else begin
                  if (rd_key < kmin_ff) begin
                     kmin_in = rd_key;
                  end
                  if (rd_key > kmax_ff) begin
                     kmax_in = rd_key;
                  end
               end
               if (!have_x_ff && rd_key == q_ff) begin
                  have_x_in = 1'b1;
                  xv_in     = rd_val;
               end
               if (rd_key < q_ff && (!have_a_ff || rd_key > a_ff)) begin
                  have_a_in = 1'b1;
                  a_in      = rd_key;
                  va_in     = rd_val;
               end
               if (rd_key > q_ff && (!have_c_ff || rd_key < c_ff)) begin
                  have_c_in = 1'b1;
                  c_in      = rd_key;
                  vc_in     = rd_val;
               end
            end
            if (!more_reads && !rdv_ff) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (q_ff < kmin_ff || q_ff > kmax_ff) begin
               pend_value_in  = '0;
               pend_status_in = tli_pkg::ST_OUT_OF_BOUNDS;
               state_in       = S_EMIT;
            end else if (have_x_ff) begin
               pend_value_in  = xv_ff;
               pend_status_in = tli_pkg::ST_EXACT;
               state_in       = S_EMIT;
            end else if (!(have_a_ff && have_c_ff)) begin
               pend_value_in  = '0;
               pend_status_in = tli_pkg::ST_OUT_OF_BOUNDS;
               state_in       = S_EMIT;
            end else begin
               dq_in    = dq_w;
               dv_in    = dv_w;
               den_in   = den_w[15:0];
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = 34'(dq_ff) * 34'(dv_ff);
            neg_in   = dv_ff[16];
            state_in = S_START;
         end
         S_START: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_res.done) begin
               pend_value_in  = res_sat;
               pend_status_in = tli_pkg::ST_INTERP;
               state_in       = S_EMIT;
            end
         end
         S_EMIT: begin
            // Hold until the result register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = pend_value_ff;
               rsp_status_in = pend_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Configuration register
   assign entries_in = csr_valid ? csr_data : entries_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         entries_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         entries_ff   <= entries_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      n_ff           <= n_in;
      rd_addr_ff     <= rd_addr_in;
      rdv_ff         <= rdv_in;
      first_ff       <= first_in;
      q_ff           <= q_in;
      kmin_ff        <= kmin_in;
      kmax_ff        <= kmax_in;
      have_x_ff      <= have_x_in;
      xv_ff          <= xv_in;
      have_a_ff      <= have_a_in;
      a_ff           <= a_in;
      va_ff          <= va_in;
      have_c_ff      <= have_c_in;
      c_ff           <= c_in;
      vc_ff          <= vc_in;
      dq_ff          <= dq_in;
      dv_ff          <= dv_in;
      den_ff         <= den_in;
      prod_ff        <= prod_in;
      neg_ff         <= neg_in;
      pend_value_ff  <= pend_value_in;
      pend_status_ff <= pend_status_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_status_ff  <= rsp_status_in;
   end

   // Ports
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign csr_ready  = 1'b1;

   // Assertions
   logic load_fire;
   logic empty_fire;

   assign load_fire  = req_tvalid && req_tready && req_op == tli_pkg::OP_LOAD;
   assign empty_fire = req_tvalid && req_tready && req_op == tli_pkg::OP_QUERY && n_sel == '0;

`include "table_linear_interpolator_assert.svh"

   `TLI_ASSERT_SAME(a_div_free_at_start, state_ff == S_START, !div_res.busy)
   `TLI_ASSERT_SAME(a_div_done_in_wait, div_res.done, state_ff == S_DIV)
   `TLI_ASSERT_NEXT(a_load_answers, load_fire, state_ff == S_EMIT && pend_status_ff == tli_pkg::ST_LOADED)
   `TLI_ASSERT_NEXT(a_empty_answers, empty_fire, state_ff == S_EMIT && pend_status_ff == tli_pkg::ST_EMPTY)

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the table linear interpolator: loads, queries and count writes.
module tb_top;

   // One request word as the stimulus sees it
   typedef struct {
      logic                             op;
      logic [tli_pkg::INDEX_W-1:0]      index;
      logic signed [tli_pkg::KEY_W-1:0] key;
      logic signed [tli_pkg::VAL_W-1:0] value;
   } table_op_type;

   // One result word
   typedef struct {
      logic signed [tli_pkg::VAL_W-1:0] value;
      tli_pkg::status_type              status;
   } lookup_result_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_tvalid = 1'b0;
   logic                                  req_tready;
   logic [tli_pkg::REQ_DATA_W-1:0]        req_tdata = '0;
   logic [0:0]                            req_tuser = '0;
   logic                                  rsp_tvalid;
   logic                                  rsp_tready = 1'b0;
   logic [tli_pkg::RSP_DATA_W-1:0]        rsp_tdata;
   logic [tli_pkg::STATUS_W-1:0]          rsp_tuser;
   logic                                  csr_valid = 1'b0;
   logic                                  csr_ready;
   logic [tli_pkg::COUNT_CFG_W-1:0]       csr_data = '0;

   // Stimulus queue and scoreboard
   table_op_type                          pending_ops[$];
   table_op_type                          op_on_bus;
   lookup_result_type                     expected_lookups[$];
   logic                                  req_taken = 1'b0;
   int                                    mismatch_count = 0;

   // Idle percentages and the long receiver hold-off
   int                                    sender_idle_pct = 0;
   int                                    receiver_idle_pct = 0;
   bit                                    pressure_go = 1'b0;
   bit                                    hold_rsp = 1'b0;

   // Predictor copy of the table and of entries_in_use
   logic signed [tli_pkg::KEY_W-1:0]      model_key [tli_pkg::TABLE_DEPTH];
   logic signed [tli_pkg::VAL_W-1:0]      model_val [tli_pkg::TABLE_DEPTH];
   logic [tli_pkg::COUNT_CFG_W-1:0]       scan_count = '0;

   // Generator shadow of the keys, kept in queue order
   logic signed [tli_pkg::KEY_W-1:0]      gen_key [tli_pkg::TABLE_DEPTH];

   table_linear_interpolator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin : clock_gen
      forever #4 clock = ~clock;
   end

   initial begin : run_limit
      #8000000;
      $display("tb_top failed");
      $finish;
   end

   // Apply one word to the predictor table and work out its result
   function automatic lookup_result_type predict_lookup(input table_op_type word);
      lookup_result_type r;
      int n, q, k, kmin, kmax, a, c, ai, ci;
      bit have_a, have_c;
      longint dv, num, den, mag, quo, res;
      r.value = '0;
      r.status = tli_pkg::ST_LOADED;
      if (word.op == tli_pkg::OP_LOAD) begin
         model_key[word.index] = word.key;
         model_val[word.index] = word.value;
         return r;
      end
      n = (scan_count > tli_pkg::TABLE_DEPTH) ? tli_pkg::TABLE_DEPTH : scan_count;
      if (n == 0) begin
         r.status = tli_pkg::ST_EMPTY;
         return r;
      end
      q = word.key;
      kmin = model_key[0];
      kmax = kmin;
      for (int i = 1; i < n; i++) begin
         k = model_key[i];
         if (k < kmin) kmin = k;
         if (k > kmax) kmax = k;
      end
      if (q < kmin || q > kmax) begin
         r.status = tli_pkg::ST_OUT_OF_BOUNDS;
         return r;
      end
      // Lowest slot wins on an exact match
      for (int i = 0; i < n; i++) begin
         if (model_key[i] == q) begin
            r.value = model_val[i];
            r.status = tli_pkg::ST_EXACT;
            return r;
         end
      end
      // Find the bracketing keys, lowest slot on ties
      have_a = 1'b0;
      have_c = 1'b0;
      a = 0;
      c = 0;
      ai = 0;
      ci = 0;
      for (int i = 0; i < n; i++) begin
         k = model_key[i];
         if (k < q && (!have_a || k > a)) begin
            a = k;
            ai = i;
            have_a = 1'b1;
         end
         if (k > q && (!have_c || k < c)) begin
            c = k;
            ci = i;
            have_c = 1'b1;
         end
      end
      if (!have_a || !have_c) begin
         r.status = tli_pkg::ST_OUT_OF_BOUNDS;
         return r;
      end
      // Round the quotient to nearest, halves away from zero, then saturate
      dv = longint'(model_val[ci]) - longint'(model_val[ai]);
      num = longint'(q - a) * dv;
      den = longint'(c - a);
      mag = (num < 0) ? -num : num;
      mag = (2 * mag + den) / (2 * den);
      quo = (num < 0) ? -mag : mag;
      res = longint'(model_val[ai]) + quo;
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      r.value = res[tli_pkg::VAL_W-1:0];
      r.status = tli_pkg::ST_INTERP;
      return r;
   endfunction

   // Queue one word and track the keys it leaves in the table
   function automatic void queue_op(input logic op, input int index, input int key,
                                    input int value);
      table_op_type word;
      word.op = op;
      word.index = index[tli_pkg::INDEX_W-1:0];
      word.key = key[tli_pkg::KEY_W-1:0];
      word.value = value[tli_pkg::VAL_W-1:0];
      if (op == tli_pkg::OP_LOAD) gen_key[word.index] = word.key;
      pending_ops.insert(pending_ops.size(), word);
   endfunction

   // Mix wide keys with a tight cluster so duplicates and near misses occur
   function automatic int random_key();
      if ($urandom_range(0, 1) == 0) return int'($urandom_range(0, 511)) - 256;
      return int'(signed'(16'($urandom())));
   endfunction

   // Random load or query; queries mostly land inside the scanned key range
   function automatic void queue_random_op(input int count);
      int n, kmin, kmax, sel, q;
      n = (count > tli_pkg::TABLE_DEPTH) ? tli_pkg::TABLE_DEPTH : count;
      if ($urandom_range(0, 99) < 25) begin
         queue_op(tli_pkg::OP_LOAD, $urandom_range(0, tli_pkg::TABLE_DEPTH - 1),
                  random_key(), $urandom());
         return;
      end
      q = int'(signed'(16'($urandom())));
      if (n > 0) begin
         kmin = gen_key[0];
         kmax = kmin;
         for (int i = 1; i < n; i++) begin
            if (gen_key[i] < kmin) kmin = gen_key[i];
            if (gen_key[i] > kmax) kmax = gen_key[i];
         end
         sel = $urandom_range(0, 9);
         if (sel < 4) begin
            q = gen_key[$urandom_range(0, n - 1)];
         end else if (sel < 8) begin
            q = kmin + int'($urandom_range(0, kmax - kmin));
         end else if (sel == 9) begin
            if (kmin > -32768) q = kmin - 1;
            else if (kmax < 32767) q = kmax + 1;
         end
      end
      queue_op(tli_pkg::OP_QUERY, $urandom_range(0, tli_pkg::TABLE_DEPTH - 1), q,
               $urandom());
   endfunction

   // Hold until every queued word is accepted and answered
   task automatic wait_table_idle();
      @(posedge clock);
      while (pending_ops.size() != 0 || expected_lookups.size() != 0 || req_tvalid)
         @(posedge clock);
   endtask

   // Write entries_in_use while the block is idle
   task automatic write_scan_count(input int count);
      wait_table_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= count[tli_pkg::COUNT_CFG_W-1:0];
      do @(posedge clock); while (!csr_ready);
      scan_count = count[tli_pkg::COUNT_CFG_W-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Request driver: advance only when the bus is empty or the word was taken
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_ops.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            op_on_bus = pending_ops.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= op_on_bus.op;
            req_tdata <= {2'b00, op_on_bus.value, op_on_bus.key, op_on_bus.index};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls plus the long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !hold_rsp && ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   // Monitor: check each result word, then predict the newly accepted word
   always @(posedge clock) begin
      lookup_result_type exp_r;
      lookup_result_type new_r;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_lookups.size() == 0) begin
            $error("unexpected result word: value_out %0d, status %0d",
                   $signed(rsp_tdata), rsp_tuser);
            mismatch_count++;
         end else begin
            exp_r = expected_lookups.pop_front();
            if (rsp_tdata !== exp_r.value) begin
               $error("value_out mismatch: expected %0d, actual %0d",
                      exp_r.value, $signed(rsp_tdata));
               mismatch_count++;
            end
            if (rsp_tuser !== exp_r.status) begin
               $error("status mismatch: expected %0d, actual %0d", exp_r.status, rsp_tuser);
               mismatch_count++;
            end
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         new_r = predict_lookup(op_on_bus);
         expected_lookups.insert(expected_lookups.size(), new_r);
      end
   end

   // Long receiver stall while the sender keeps offering
   initial begin : receiver_hold_off
      wait (pressure_go);
      @(posedge clock);
      hold_rsp = 1'b1;
      repeat (300) @(posedge clock);
      hold_rsp = 1'b0;
   end

   initial begin : stimulus
      int count, len, phase_items, seg;
      sender_idle_pct = 17;
      receiver_idle_pct = 56;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty table after reset
      queue_op(tli_pkg::OP_QUERY, 63, 0, 0);
      // Small table with key and value extremes and a duplicate key
      queue_op(tli_pkg::OP_LOAD, 0, 0, 0);
      queue_op(tli_pkg::OP_LOAD, 1, 256, 4096);
      queue_op(tli_pkg::OP_LOAD, 2, 256, -4096);
      queue_op(tli_pkg::OP_LOAD, 3, -32768, 32767);
      queue_op(tli_pkg::OP_LOAD, 4, 32767, -32768);
      queue_op(tli_pkg::OP_LOAD, 5, -256, 32767);

      // Three slots: bounds, duplicate match, midpoint
      write_scan_count(3);
      queue_op(tli_pkg::OP_QUERY, 0, -1, 0);
      queue_op(tli_pkg::OP_QUERY, 0, 257, 0);
      queue_op(tli_pkg::OP_QUERY, 0, 256, 0);
      queue_op(tli_pkg::OP_QUERY, 0, 128, 0);
      queue_op(tli_pkg::OP_QUERY, 0, 0, 0);

      // Six slots: full key range and steep slopes
      write_scan_count(6);
      queue_op(tli_pkg::OP_QUERY, 0, -32768, 0);
      queue_op(tli_pkg::OP_QUERY, 0, 32767, 0);
      queue_op(tli_pkg::OP_QUERY, 0, 300, 0);
      queue_op(tli_pkg::OP_QUERY, 0, -1, 0);
      queue_op(tli_pkg::OP_QUERY, 0, -32767, 0);

      // Single slot, then cleared count
      write_scan_count(1);
      queue_op(tli_pkg::OP_QUERY, 0, 0, 0);
      queue_op(tli_pkg::OP_QUERY, 0, 5, 0);
      write_scan_count(0);
      queue_op(tli_pkg::OP_QUERY, 42, 1000, 0);

      // Fill every slot so any count is legal afterwards
      for (int i = 0; i < tli_pkg::TABLE_DEPTH; i++)
         queue_op(tli_pkg::OP_LOAD, i, random_key(), $urandom());

      for (int phase = 0; phase < 3; phase++) begin
         wait_table_idle();
         case (phase)
            0: begin
               sender_idle_pct = 17;
               receiver_idle_pct = 56;
            end
            1: begin
               sender_idle_pct = 56;
               receiver_idle_pct = 17;
            end
            default: begin
               sender_idle_pct = 0;
               receiver_idle_pct = 0;
            end
         endcase
         phase_items = 0;
         seg = 0;
         while (phase_items < 240) begin
            // Pick a count, forcing the oversize and full-depth cases first
            if (phase == 0 && seg == 0) begin
               count = 127;
            end else if (phase == 0 && seg == 1) begin
               count = tli_pkg::TABLE_DEPTH;
            end else begin
               case ($urandom_range(0, 5))
                  0: count = 0;
                  1: count = 1;
                  2: count = $urandom_range(2, 8);
                  3: count = tli_pkg::TABLE_DEPTH;
                  4: count = 127;
                  default: count = $urandom_range(0, 127);
               endcase
            end
            write_scan_count(count);
            len = $urandom_range(20, 60);
            for (int i = 0; i < len; i++) queue_random_op(count);
            if (phase == 2 && seg == 0) pressure_go = 1'b1;
            phase_items += len;
            seg++;
         end
      end

      wait_table_idle();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
